// File: src/vibrato_modulated_delay_unit_defines.svh
// Assertion macros shared by the checker files of the vibrato delay unit.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef VIBRATO_MODULATED_DELAY_UNIT_DEFINES_SVH
`define VIBRATO_MODULATED_DELAY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define VMD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vibrato delay unit check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define VMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vibrato delay unit check failed");

`endif

// File: src/vmd_pkg.sv
// Shared constants, types and the quarter-wave sine table builder for the
// vibrato delay unit. No dependencies.
package vmd_pkg;

  localparam int MAX_WIDTH       = 4096;
  localparam int SAMPLE_BITS     = 24;
  localparam int SINE_TABLE_BITS = 10;

  localparam int SINE_N      = 1 << SINE_TABLE_BITS;
  localparam int STORE_DEPTH = 2 + 3 * MAX_WIDTH;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int PHASE_BITS  = 32;
  localparam int WIDTH_BITS  = 13;
  localparam int SINE_BITS   = 15;
  localparam int FRAC_BITS   = 16;
  localparam int TAP_BITS    = ADDR_BITS + FRAC_BITS;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INC = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH     = CFG_INDEX_BITS'(1);

  localparam logic [PHASE_BITS-1:0] PHASE_INC_RESET = PHASE_BITS'(447392);
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET     = WIDTH_BITS'(240);

  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SINE_BITS-1:0]          sine_mag_t;
  typedef sine_mag_t                     sine_rom_t [0:SINE_N];

  // write and read requests to the delay store, issued together
  typedef struct packed {
    logic    wr_en;
    addr_t   wr_addr;
    sample_t wr_data;
    addr_t   rd_addr;
  } store_req_t;

  // Quarter-wave sine magnitude, unsigned Q0.15, from a Q30 Taylor series to the 13th order.
  function automatic sine_rom_t sine_rom();
    sine_rom_t          t;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        e;
    for (int k = 0; k <= SINE_N; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      term = x;
      sum  = signed'(x);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'd156;
      sum  = sum + signed'(term);
      if (sum < 0) begin
        sum = 0;
      end
      e = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      t[k] = SINE_BITS'(e);
    end
    return t;
  endfunction

endpackage

// File: src/vmd_store.sv
// Delay store: one write and one registered read per cycle, with a fill mark.
// Depends on vmd_pkg for the address and sample types.
module vmd_store (
  input  logic                clk,
  input  logic                rst,
  input  vmd_pkg::store_req_t req,
  output vmd_pkg::sample_t    rd_data
);

  vmd_pkg::sample_t mem [0:vmd_pkg::STORE_DEPTH-1];
  vmd_pkg::sample_t mem_q;
  logic             hit;
  // Writes always land at 0 or one past the last one, so the written entries
  // form a prefix; everything at or above the fill mark still reads as zero.
  logic [vmd_pkg::ADDR_BITS:0] fill;

  // fill mark
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (req.wr_en && ((vmd_pkg::ADDR_BITS+1)'(req.wr_addr) >= fill)) begin
      fill <= (vmd_pkg::ADDR_BITS+1)'(req.wr_addr) + (vmd_pkg::ADDR_BITS+1)'(1);
    end
  end

  // memory array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    mem_q <= mem[req.rd_addr];
    hit   <= (vmd_pkg::ADDR_BITS+1)'(req.rd_addr) < fill;
  end

  assign rd_data = hit ? mem_q : '0;

endmodule

// File: src/vibrato_modulated_delay_unit.sv
// Vibrato: sine-modulated fractional delay line, top level.
// Depends on vmd_pkg and vmd_store.
//
//   channel   signals                        beat
//   input     in_valid / in_ready            sample_in, signed Q1.23
//   output    out_valid / out_ready          sample_out, signed Q1.23
//   config    cfg_we, cfg_index, cfg_data    one register write per cycle
//
// Per item: sine table read on accept, tap multiply, address, then two reads
// of the single-read-port store and the interpolation multiply before the
// result is loaded. The next beat is taken on return to idle, so the unit
// takes no new item until it is through with the last one. The result
// register lets the next beat in while a result waits; a stalled result
// holds the unit in its last step. Reset is synchronous and needs no clearing
// pass: a fill mark in the store makes unwritten entries read as zero.
module vibrato_modulated_delay_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vmd_pkg::sample_t                    sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vmd_pkg::sample_t                    sample_out,
  input  logic                                cfg_we,
  input  logic [vmd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vmd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int RomIdxBits = vmd_pkg::SINE_TABLE_BITS + 1;
  localparam int MulBits    = vmd_pkg::WIDTH_BITS + vmd_pkg::SINE_BITS + 2;
  localparam int DiffBits   = vmd_pkg::SAMPLE_BITS + 1;
  localparam int MixBits    = DiffBits + vmd_pkg::FRAC_BITS + 1;
  localparam int YBits      = vmd_pkg::SAMPLE_BITS + 2;

  localparam logic signed [MixBits-1:0] RoundBias =
    MixBits'(1 << (vmd_pkg::FRAC_BITS - 1));
  localparam logic signed [YBits-1:0] SampleMax =
    YBits'((1 << (vmd_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [YBits-1:0] SampleMin = -SampleMax - YBits'(1);

  localparam vmd_pkg::sine_rom_t SineRom = vmd_pkg::sine_rom();

  typedef enum logic [2:0] {
    S_IDLE, S_TAP, S_ADDR, S_RDA, S_RDB, S_DIFF, S_MUL, S_DONE
  } state_t;

  state_t                            state;
  logic [vmd_pkg::PHASE_BITS-1:0]    phase_inc;
  logic [vmd_pkg::WIDTH_BITS-1:0]    width_reg;
  vmd_pkg::addr_t                    wp;
  logic [vmd_pkg::PHASE_BITS-1:0]    mod_phase;

  // per-item working registers
  logic [vmd_pkg::WIDTH_BITS-1:0]    w_q;
  vmd_pkg::addr_t                    len_q;
  vmd_pkg::addr_t                    wp_q;
  vmd_pkg::sine_mag_t                sine_mag;
  logic                              sine_neg;
  logic signed [vmd_pkg::TAP_BITS:0] prod;
  vmd_pkg::addr_t                    rp_q;
  vmd_pkg::addr_t                    rq_q;
  logic [vmd_pkg::FRAC_BITS-1:0]     frac_q;
  vmd_pkg::sample_t                  a_q;
  logic signed [DiffBits-1:0]        diff_q;
  logic signed [MixBits-1:0]         mix_q;

  logic                              accept;
  logic [vmd_pkg::WIDTH_BITS-1:0]    w_clamp;
  vmd_pkg::addr_t                    len_now;
  vmd_pkg::addr_t                    wp_eff;
  vmd_pkg::addr_t                    wp_inc;
  logic [vmd_pkg::SINE_TABLE_BITS-1:0] phase_n;
  logic [RomIdxBits-1:0]             rom_idx;
  logic signed [vmd_pkg::SINE_BITS:0] sine_val;
  logic signed [MulBits-1:0]         ws_mul;
  logic signed [vmd_pkg::TAP_BITS:0] prod_ext;
  logic signed [vmd_pkg::TAP_BITS:0] tap;
  vmd_pkg::addr_t                    ip;
  logic [vmd_pkg::ADDR_BITS:0]       rp_sum;
  vmd_pkg::addr_t                    rp_next;
  logic signed [YBits-1:0]           y_full;
  vmd_pkg::sample_t                  y_sat;
  vmd_pkg::store_req_t               store_req;
  vmd_pkg::sample_t                  rd_data;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // line geometry for the incoming beat
  always_comb begin
    if (32'(width_reg) > vmd_pkg::MAX_WIDTH) begin
      w_clamp = vmd_pkg::WIDTH_BITS'(vmd_pkg::MAX_WIDTH);
    end else begin
      w_clamp = width_reg;
    end
    len_now = vmd_pkg::ADDR_BITS'({w_clamp, 1'b0}) + vmd_pkg::ADDR_BITS'(w_clamp)
            + vmd_pkg::ADDR_BITS'(2);
    wp_eff  = (wp >= len_now) ? '0 : wp;
    wp_inc  = (wp_eff + vmd_pkg::ADDR_BITS'(1) >= len_now) ? '0
            : wp_eff + vmd_pkg::ADDR_BITS'(1);
  end

  // quadrant folding of the table index
  assign phase_n = mod_phase[vmd_pkg::PHASE_BITS-3 -: vmd_pkg::SINE_TABLE_BITS];
  assign rom_idx = mod_phase[vmd_pkg::PHASE_BITS-2]
                 ? RomIdxBits'(vmd_pkg::SINE_N) - RomIdxBits'(phase_n)
                 : RomIdxBits'(phase_n);

  // signed sine times width
  assign sine_val = sine_neg ? -signed'({1'b0, sine_mag}) : signed'({1'b0, sine_mag});
  assign ws_mul   = signed'({1'b0, w_q}) * sine_val;
  assign prod_ext = (vmd_pkg::TAP_BITS+1)'(ws_mul);

  // tap position and the newer read address
  always_comb begin
    tap = signed'((vmd_pkg::TAP_BITS+1)'({(vmd_pkg::WIDTH_BITS+1)'(w_q)
                 + (vmd_pkg::WIDTH_BITS+1)'(1), vmd_pkg::FRAC_BITS'(0)})) + prod;
    ip  = tap[vmd_pkg::TAP_BITS-1:vmd_pkg::FRAC_BITS];
    rp_sum = (vmd_pkg::ADDR_BITS+1)'(wp_q) + (vmd_pkg::ADDR_BITS+1)'(len_q)
           - (vmd_pkg::ADDR_BITS+1)'(ip);
    if (rp_sum >= (vmd_pkg::ADDR_BITS+1)'(len_q)) begin
      rp_next = vmd_pkg::ADDR_BITS'(rp_sum - (vmd_pkg::ADDR_BITS+1)'(len_q));
    end else begin
      rp_next = vmd_pkg::ADDR_BITS'(rp_sum);
    end
  end

  // rounding and saturation of the interpolated sample
  always_comb begin
    y_full = YBits'((mix_q + RoundBias) >>> vmd_pkg::FRAC_BITS) + YBits'(a_q);
    if (y_full > SampleMax) begin
      y_sat = vmd_pkg::SAMPLE_BITS'(SampleMax);
    end else if (y_full < SampleMin) begin
      y_sat = vmd_pkg::SAMPLE_BITS'(SampleMin);
    end else begin
      y_sat = vmd_pkg::SAMPLE_BITS'(y_full);
    end
  end

  // store requests: write on accept, read the newer tap then the older one
  always_comb begin
    store_req.wr_en   = accept;
    store_req.wr_addr = wp_eff;
    store_req.wr_data = sample_in;
    store_req.rd_addr = (state == S_RDB) ? rq_q : rp_q;
  end

  vmd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data)
  );

  // quarter-wave table, registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      sine_mag <= SineRom[rom_idx];
      sine_neg <= mod_phase[vmd_pkg::PHASE_BITS-1];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc <= vmd_pkg::PHASE_INC_RESET;
      width_reg <= vmd_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vmd_pkg::REG_PHASE_INC: phase_inc <= cfg_data[vmd_pkg::PHASE_BITS-1:0];
        vmd_pkg::REG_WIDTH:     width_reg <= cfg_data[vmd_pkg::WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, line state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      mod_phase <= '0;
      out_valid <= 1'b0;
    end else begin
      // the last step reloads the result itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            w_q       <= w_clamp;
            len_q     <= len_now;
            wp_q      <= wp_eff;
            wp        <= wp_inc;
            mod_phase <= mod_phase + phase_inc;
            state     <= S_TAP;
          end
        end
        S_TAP: begin
          prod  <= prod_ext <<< 1;
          state <= S_ADDR;
        end
        S_ADDR: begin
          rp_q   <= rp_next;
          frac_q <= tap[vmd_pkg::FRAC_BITS-1:0];
          state  <= S_RDA;
        end
        S_RDA: begin
          rq_q  <= (rp_q == '0) ? len_q - vmd_pkg::ADDR_BITS'(1)
                 : rp_q - vmd_pkg::ADDR_BITS'(1);
          state <= S_RDB;
        end
        S_RDB: begin
          a_q   <= rd_data;
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff_q <= DiffBits'(rd_data) - DiffBits'(a_q);
          state  <= S_MUL;
        end
        S_MUL: begin
          mix_q <= diff_q * signed'({1'b0, frac_q});
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            sample_out <= y_sat;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/vmd_checker.sv
// Port-level checks for the vibrato delay unit, bound to the top level.
// Depends on vmd_pkg and vibrato_modulated_delay_unit_defines.svh.
`include "vibrato_modulated_delay_unit_defines.svh"

module vmd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input vmd_pkg::sample_t                    sample_out
);

  // one item at a time: an accepted beat closes the input
  `VMD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // the input is still closed when the computation reaches its last step
  `VMD_ASSERT_NOW(a_busy_span, clk, rst, in_valid && in_ready, ##7 !in_ready)

  // a result is loaded only from the last step, never while idle
  `VMD_ASSERT_NOW(a_result_from_work, clk, rst, $rose(out_valid), $past(!in_ready))

  // a stalled result holds its value
  `VMD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(sample_out))

endmodule

bind vibrato_modulated_delay_unit vmd_checker u_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for vibrato_modulated_delay_unit: a scoreboard class
// predicts each output beat from the sine-modulated tap, plain tasks drive the input
// channel and config port, and a receiver block drives out_ready. Depends on vmd_pkg and the unit.
module testbench;

  // Predicts the interpolated delay-line output and queues it per input beat
  class delay_line_scoreboard;
    int unsigned      quarter_sine [0:vmd_pkg::SINE_N];
    vmd_pkg::sample_t line_mem [0:vmd_pkg::STORE_DEPTH-1];
    logic [31:0]      phase_inc;
    logic [31:0]      phase_acc;
    logic [12:0]      width_reg;
    int unsigned      wr_pos;
    vmd_pkg::sample_t pending_outputs [$];
    int               failures;
    int               samples_in;
    int               outputs_checked;

    function new();
      longint unsigned x;
      longint unsigned term;
      longint unsigned e;
      longint          sum;
      // Q30 Taylor series for sin over the first quarter wave
      for (int k = 0; k <= vmd_pkg::SINE_N; k++) begin
        x = (64'd1686629713 * longint'(k)) >> vmd_pkg::SINE_TABLE_BITS;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 6; n++) begin
          term = (term * x) >> 30;
          term = ((term * x) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        e = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
        if (e > 32767) e = 32767;
        quarter_sine[k] = int'(e);
      end
      foreach (line_mem[i]) line_mem[i] = '0;
      phase_inc = vmd_pkg::PHASE_INC_RESET;
      width_reg = vmd_pkg::WIDTH_RESET;
      phase_acc = '0;
      wr_pos = 0;
      failures = 0;
      samples_in = 0;
      outputs_checked = 0;
    endfunction

    function void set_reg(logic [vmd_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
      if (idx == vmd_pkg::REG_PHASE_INC) phase_inc = data;
      else if (idx == vmd_pkg::REG_WIDTH) width_reg = data[12:0];
    endfunction

    function int sine_at(logic [31:0] ph);
      int unsigned n;
      int          v;
      n = ph[29:20];
      v = ph[30] ? quarter_sine[vmd_pkg::SINE_N - n] : quarter_sine[n];
      return ph[31] ? -v : v;
    endfunction

    // One step of the delay line: write, tap, interpolate, advance
    function vmd_pkg::sample_t delayed_sample(vmd_pkg::sample_t x);
      int unsigned w;
      int unsigned len;
      int unsigned ip;
      int unsigned frac;
      int unsigned rp;
      int unsigned rq;
      longint      tap;
      longint      a;
      longint      b;
      longint      y;
      w = width_reg;
      if (w > vmd_pkg::MAX_WIDTH) w = vmd_pkg::MAX_WIDTH;
      len = 2 + 3 * w;
      // line shrank under the write position
      if (wr_pos >= len) wr_pos = 0;
      line_mem[wr_pos] = x;
      tap = (longint'(1 + w) << 16) + 2 * longint'(w) * longint'(sine_at(phase_acc));
      ip = int'(tap >> 16);
      frac = int'(tap & 64'hFFFF);
      phase_acc = phase_acc + phase_inc;
      rp = (wr_pos + len - ip) % len;
      rq = (rp + len - 1) % len;
      a = longint'(line_mem[rp]);
      b = longint'(line_mem[rq]);
      // weight frac on the older sample, round half up
      y = (a * longint'(65536 - frac) + b * longint'(frac) + 32768) >>> 16;
      if (y > 64'sd8388607) y = 64'sd8388607;
      if (y < -64'sd8388608) y = -64'sd8388608;
      wr_pos = wr_pos + 1;
      if (wr_pos >= len) wr_pos = 0;
      return vmd_pkg::sample_t'(y);
    endfunction

    function void take_sample(vmd_pkg::sample_t x);
      pending_outputs.push_back(delayed_sample(x));
      samples_in++;
    endfunction

    function void compare_output(vmd_pkg::sample_t y);
      vmd_pkg::sample_t want;
      if (pending_outputs.size() == 0) begin
        $error("sample_out: unexpected beat, expected none, actual %0d", y);
        failures++;
      end else begin
        want = pending_outputs.pop_front();
        if (want !== y) begin
          $error("sample_out mismatch: expected %0d, actual %0d", want, y);
          failures++;
        end
      end
      outputs_checked++;
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  vmd_pkg::sample_t                    sample_in = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  vmd_pkg::sample_t                    sample_out;
  logic                                cfg_we = 1'b0;
  logic [vmd_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [vmd_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;

  delay_line_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int settings_used = 0;

  vibrato_modulated_delay_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_left = 400;
      hold_done++;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Beat monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.take_sample(sample_in);
      if (out_valid && out_ready) sb.compare_output(sample_out);
    end
  end

  // Offer one input beat; called and returns at a falling edge
  task automatic send_sample(input vmd_pkg::sample_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_in = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait out every outstanding result
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_outputs.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [vmd_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [31:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [31:0] inc, input int unsigned wd);
    wait_drained();
    write_reg(vmd_pkg::REG_PHASE_INC, inc);
    write_reg(vmd_pkg::REG_WIDTH, 32'(wd));
    settings_used++;
  endtask

  function automatic vmd_pkg::sample_t rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return vmd_pkg::sample_t'($signed(r[3:0]));
      default: return r[23:0];
    endcase
  endfunction

  initial begin
    logic [31:0] inc_pick;
    int unsigned wd_pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 68;

    // Reset settings: long tap, outputs read the cleared line
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);

    // Zero width, frozen phase: output is the previous sample; the shorter
    // line also forces the write position back to zero
    apply_setting(32'h0000_0000, 0);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h000001);
    send_sample(24'hFFFFFF);
    send_sample(24'h000000);
    send_sample(24'h800000);
    send_sample(24'h800000);

    // Width above the maximum clamps; phase steps backward, wrapping at once
    apply_setting(32'hFFFF_FFFF, 8191);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);

    // Width one, quarter-turn steps: tap visits every quadrant peak
    apply_setting(32'h4000_0000, 1);
    for (int i = 0; i < 8; i++) send_sample((i % 2 == 0) ? 24'h7FFFFF : 24'h800000);

    // Random phases: each picks a setting, then a burst of random beats
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: wd_pick = $urandom_range(0, 40);
        5, 6: wd_pick = $urandom_range(41, 700);
        7: wd_pick = $urandom_range(4097, 8191);
        8: wd_pick = vmd_pkg::MAX_WIDTH;
        default: wd_pick = $urandom_range(0, 1);
      endcase
      case ($urandom_range(7))
        0, 1, 2: inc_pick = $urandom;
        3: inc_pick = $urandom_range(0, 32'h00FF_FFFF);
        4: inc_pick = 32'h0000_0000;
        5: inc_pick = 32'hFFFF_FFFF;
        6: inc_pick = $urandom | 32'hF000_0000;
        default: inc_pick = vmd_pkg::PHASE_INC_RESET;
      endcase
      // idle patterns: sender-light, then receiver-light, then none
      if (ph < 5) begin
        send_idle_pct = 37;
        recv_idle_pct = 68;
      end else if (ph < 10) begin
        send_idle_pct = 68;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(inc_pick, wd_pick);
      // long output stall while input keeps coming
      if (ph == 2) hold_req++;
      for (int i = 0; i < 125; i++) begin
        // sender pause until the unit is empty
        if (ph == 6 && i == 60) wait_drained();
        send_sample(rand_sample());
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);

    $display("testbench: %0d samples in, %0d outputs checked, %0d register settings",
             sb.samples_in, sb.outputs_checked, settings_used);
    $display("testbench: widths 0 to beyond max, phase steps 0 to all ones, stalls on both sides");
    if (sb.failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
